/* sv/mtes_pkg.sv */
// Package: shared types and constants for the MIDI track event serializer.
`timescale 1ns / 1ps

package mtes_pkg;

	// Event kinds as carried on the input channel
	typedef enum logic [1:0] {
		KIND_NOTE_OFF = 2'd0,
		KIND_PEDAL    = 2'd1,
		KIND_NOTE_ON  = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	localparam int unsigned FRAME_BYTES = 8;
	localparam int unsigned VLQ_GROUPS  = 5;

	localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
	localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
	localparam logic [7:0] STATUS_CTRL     = 8'hB0;
	localparam logic [7:0] CTRL_SUSTAIN    = 8'd64;
	localparam logic [7:0] META_PREFIX     = 8'hFF;
	localparam logic [7:0] META_END_TRACK  = 8'h2F;
	localparam logic [7:0] VLQ_CONT        = 8'h80;

	// One encoded event: up to eight bytes and the count in use
	typedef struct packed {
		logic [FRAME_BYTES-1:0][7:0] bytes;
		logic [3:0]                  len;
	} frame_t;

endpackage

/* sv/mtes_evt_if.sv */
// Interface: input channel carrying one channel event per item.
`timescale 1ns / 1ps

interface mtes_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] event_time;
	logic [3:0]  channel;
	logic [6:0]  key;
	logic [6:0]  level;

	modport source (output valid, kind, event_time, channel, key, level, input ready);
	modport sink   (input valid, kind, event_time, channel, key, level, output ready);
endinterface

/* sv/mtes_byte_if.sv */
// Interface: output channel carrying one track body byte per item.
`timescale 1ns / 1ps

interface mtes_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic       last_byte;

	modport source (output valid, byte_out, last_byte, input ready);
	modport sink   (input valid, byte_out, last_byte, output ready);
endinterface

/* sv/mtes_encoder.sv */
// Encoder: delta time, VLQ packing and message bytes into a frame register.
`timescale 1ns / 1ps

module mtes_encoder (
	input  logic              clk,
	input  logic              arst_n,
	mtes_evt_if.sink          evt,
	output logic              frame_vld,
	input  logic              frame_rdy,
	output mtes_pkg::frame_t  frame
);

	logic [31:0]          prev_time_q;
	logic [31:0]          delta;
	logic [2:0]           n_grp;
	logic [7:0][7:0]      grp;
	logic [3:0][7:0]      msg;
	mtes_pkg::kind_t      kind;
	mtes_pkg::frame_t     frame_d;
	mtes_pkg::frame_t     frame_s1;
	logic                 frame_vld_s1;
	logic                 accept;

	assign kind      = mtes_pkg::kind_t'(evt.kind);
	assign evt.ready = !frame_vld_s1 || frame_rdy;
	assign accept    = evt.valid && evt.ready;
	assign delta     = evt.event_time - prev_time_q;

	// Count the 7-bit groups the delta needs
	always_comb begin
		priority if (delta[31:28] != 4'd0) n_grp = 3'd5;
		else if (delta[27:21] != 7'd0)     n_grp = 3'd4;
		else if (delta[20:14] != 7'd0)     n_grp = 3'd3;
		else if (delta[13:7] != 7'd0)      n_grp = 3'd2;
		else                               n_grp = 3'd1;
	end

	// Split the delta into groups, least significant first
	always_comb begin
		grp    = '0;
		grp[0] = {1'b0, delta[6:0]};
		grp[1] = {1'b0, delta[13:7]};
		grp[2] = {1'b0, delta[20:14]};
		grp[3] = {1'b0, delta[27:21]};
		grp[4] = {4'd0, delta[31:28]};
	end

	// Pick the three message bytes
	always_comb begin
		msg = '0;
		unique case (kind)
			mtes_pkg::KIND_NOTE_OFF: begin
				msg[0] = mtes_pkg::STATUS_NOTE_OFF | {4'd0, evt.channel};
				msg[1] = {1'b0, evt.key};
				msg[2] = 8'd0;
			end
			mtes_pkg::KIND_PEDAL: begin
				msg[0] = mtes_pkg::STATUS_CTRL | {4'd0, evt.channel};
				msg[1] = mtes_pkg::CTRL_SUSTAIN;
				msg[2] = {1'b0, evt.level};
			end
			default: begin
				msg[0] = mtes_pkg::STATUS_NOTE_ON | {4'd0, evt.channel};
				msg[1] = {1'b0, evt.key};
				msg[2] = {1'b0, evt.level};
			end
		endcase
	end

	// Lay out the frame: VLQ bytes most significant first, then the message; end of track gets the fixed meta frame
	always_comb begin
		logic [3:0] pos;
		logic [2:0] gi;
		logic [3:0] mi;
		pos     = '0;
		gi      = '0;
		mi      = '0;
		frame_d = '0;
		if (kind == mtes_pkg::KIND_END) begin
			frame_d.bytes[0] = 8'd0;
			frame_d.bytes[1] = mtes_pkg::META_PREFIX;
			frame_d.bytes[2] = mtes_pkg::META_END_TRACK;
			frame_d.bytes[3] = 8'd0;
			frame_d.len      = 4'd4;
		end else begin
			for (int i = 0; i < mtes_pkg::FRAME_BYTES; i++) begin
				pos = 4'(i);
				gi  = 3'(n_grp - pos[2:0] - 3'd1);
				mi  = pos - {1'b0, n_grp};
				if (pos < {1'b0, n_grp}) begin
					frame_d.bytes[pos[2:0]] = grp[gi] |
						((pos + 4'd1 < {1'b0, n_grp}) ? mtes_pkg::VLQ_CONT : 8'd0);
				end else begin
					frame_d.bytes[pos[2:0]] = msg[mi[1:0]];
				end
			end
			frame_d.len = {1'b0, n_grp} + 4'd3;
		end
	end

	// Hold the last event time; end of track clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
		end else if (accept) begin
			prev_time_q <= (kind == mtes_pkg::KIND_END) ? 32'd0 : evt.event_time;
		end
	end

	// Frame register: load on accept, drop once handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_vld_s1 <= 1'b0;
		end else if (accept) begin
			frame_vld_s1 <= 1'b1;
		end else if (frame_rdy) begin
			frame_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frame_d;
		end
	end

	assign frame_vld = frame_vld_s1;
	assign frame     = frame_s1;

endmodule

/* sv/mtes_serializer.sv */
// Serializer: sends a frame one byte per cycle on the output channel while the output is ready.
`timescale 1ns / 1ps

module mtes_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_vld,
	output logic              frame_rdy,
	input  mtes_pkg::frame_t  frame,
	mtes_byte_if.source       body
);

	mtes_pkg::frame_t frame_q;
	logic             busy_q;
	logic [2:0]       idx_q;
	logic             is_last;
	logic             take;
	logic             load;

	assign is_last   = ({1'b0, idx_q} + 4'd1) == frame_q.len;
	assign take      = body.valid && body.ready;
	assign frame_rdy = !busy_q || (take && is_last);
	assign load      = frame_vld && frame_rdy;

	assign body.valid     = busy_q;
	assign body.byte_out  = frame_q.bytes[idx_q];
	assign body.last_byte = is_last;

	// Advance through the frame, load the next one after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
	end

endmodule

/* sv/midi_track_event_serializer.sv */
// Top level: MIDI track event serializer, events in, track body bytes out.
//
//   channel  dir  payload                                    per item
//   evt      in   kind, event_time, channel, key, level      one event
//   body     out  byte_out, last_byte                        one byte
//
// An event is encoded into a frame of 4 to 8 bytes in the encoder's register
// when it is accepted, and moves into the byte sender once that can take it;
// its bytes are sent from there. Bytes go out one a cycle while the output is
// ready. One frame waits behind the one being sent, so input is taken while
// output stalls until both are full. Reset clears the stored time and empties
// both.
`timescale 1ns / 1ps

module midi_track_event_serializer (
	input  logic        clk,
	input  logic        arst_n,
	mtes_evt_if.sink    evt,
	mtes_byte_if.source body
);

	mtes_pkg::frame_t frame;
	logic             frame_vld;
	logic             frame_rdy;

	mtes_encoder u_encoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt),
		.frame_vld (frame_vld),
		.frame_rdy (frame_rdy),
		.frame     (frame)
	);

	mtes_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_vld (frame_vld),
		.frame_rdy (frame_rdy),
		.frame     (frame),
		.body      (body)
	);

endmodule

/* sim/tb_top.sv */
// Testbench: drives channel events into the track event serializer and checks its bytes.
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		mtes_pkg::kind_t kind;
		logic [31:0]     tick;
		logic [3:0]      channel;
		logic [6:0]      key;
		logic [6:0]      level;
	} track_event_t;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} body_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	mtes_evt_if  evt_ch ();
	mtes_byte_if body_ch ();

	midi_track_event_serializer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.body   (body_ch)
	);

	track_event_t event_queue[$];
	body_byte_t   body_due[$];
	track_event_t next_event;

	// predictor state: time of the last encoded event
	logic [31:0] last_tick = '0;
	// stimulus side: time of the last queued event
	logic [31:0] track_tick = '0;

	bit send_gaps = 1'b1;
	bit take_gaps = 1'b1;
	int hold_requests = 0;
	int hold_seen;
	int hold_left;

	int errors = 0;
	int events_in = 0;
	int ends_in = 0;
	int bytes_checked = 0;

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// reset: assert once at the start, then release
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// Append one expected byte to the tail of body_due
	function automatic void due_add(logic [7:0] value, logic last);
		body_byte_t b;
		b.value = value;
		b.last = last;
		body_due = {body_due, b};
	endfunction

	// Expected body bytes for one event, appended to body_due
	function automatic void encode_event(track_event_t ev);
		logic [34:0] delta;
		int          groups;
		logic [7:0]  status;
		logic [7:0]  data1;
		logic [7:0]  data2;
		if (ev.kind == mtes_pkg::KIND_END) begin
			due_add(8'h00, 1'b0);
			due_add(mtes_pkg::META_PREFIX, 1'b0);
			due_add(mtes_pkg::META_END_TRACK, 1'b0);
			due_add(8'h00, 1'b1);
			last_tick = '0;
			return;
		end
		delta = {3'b000, ev.tick - last_tick};
		last_tick = ev.tick;
		groups = 1;
		while (groups < mtes_pkg::VLQ_GROUPS && (delta >> (7 * groups)) != 0)
			groups++;
		// most significant group first, continuation bit on all but the last
		for (int i = groups - 1; i >= 0; i--)
			due_add(((i != 0) ? mtes_pkg::VLQ_CONT : 8'h00) | {1'b0, delta[7*i +: 7]},
				1'b0);
		case (ev.kind)
			mtes_pkg::KIND_NOTE_OFF: begin
				status = mtes_pkg::STATUS_NOTE_OFF | {4'h0, ev.channel};
				data1 = {1'b0, ev.key};
				data2 = 8'h00;
			end
			mtes_pkg::KIND_PEDAL: begin
				status = mtes_pkg::STATUS_CTRL | {4'h0, ev.channel};
				data1 = mtes_pkg::CTRL_SUSTAIN;
				data2 = {1'b0, ev.level};
			end
			default: begin
				status = mtes_pkg::STATUS_NOTE_ON | {4'h0, ev.channel};
				data1 = {1'b0, ev.key};
				data2 = {1'b0, ev.level};
			end
		endcase
		due_add(status, 1'b0);
		due_add(data1, 1'b0);
		due_add(data2, 1'b1);
	endfunction

	// Queue one event and track the running stimulus time
	task automatic queue_event(mtes_pkg::kind_t k, logic [31:0] t, logic [3:0] ch,
			logic [6:0] ky, logic [6:0] lv);
		track_event_t ev;
		ev = '{k, t, ch, ky, lv};
		event_queue = {event_queue, ev};
		track_tick = (k == mtes_pkg::KIND_END) ? 32'd0 : t;
	endtask

	// Queue random events: mostly ordered tracks, some wraps and backward steps
	task automatic queue_random(int count);
		int          roll;
		logic [31:0] t;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				queue_event(mtes_pkg::KIND_END, $urandom, 4'($urandom), 7'($urandom),
					7'($urandom));
				continue;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: t = track_tick + $urandom_range(0, 127);
				4, 5:       t = track_tick + $urandom_range(0, 16383);
				6:          t = track_tick + $urandom_range(0, 32'h1F_FFFF);
				7:          t = track_tick + $urandom_range(0, 32'h0FFF_FFFF);
				8:          t = $urandom;
				default:    t = $urandom_range(0, track_tick);
			endcase
			queue_event(mtes_pkg::kind_t'($urandom_range(0, 2)), t, 4'($urandom),
				7'($urandom), 7'($urandom));
		end
	endtask

	// Wait until every event is sent and every byte has arrived
	task automatic drain();
		do
			@(negedge clk);
		while (event_queue.size() != 0 || evt_ch.valid || body_due.size() != 0);
	endtask

	// Event driver: predict on accept, then offer the next item or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_ch.valid <= 1'b0;
			evt_ch.kind <= mtes_pkg::KIND_NOTE_OFF;
			evt_ch.event_time <= '0;
			evt_ch.channel <= '0;
			evt_ch.key <= '0;
			evt_ch.level <= '0;
		end else begin
			if (evt_ch.valid && evt_ch.ready) begin
				encode_event('{mtes_pkg::kind_t'(evt_ch.kind), evt_ch.event_time,
					evt_ch.channel, evt_ch.key, evt_ch.level});
				events_in++;
				if (evt_ch.kind == mtes_pkg::KIND_END)
					ends_in++;
			end
			if (!evt_ch.valid || evt_ch.ready) begin
				if (event_queue.size() != 0 && !(send_gaps && $urandom_range(0, 99) < 19)) begin
					next_event = event_queue.pop_front();
					evt_ch.valid <= 1'b1;
					evt_ch.kind <= next_event.kind;
					evt_ch.event_time <= next_event.tick;
					evt_ch.channel <= next_event.channel;
					evt_ch.key <= next_event.key;
					evt_ch.level <= next_event.level;
				end else begin
					evt_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output hold-off: count down a long stall when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= 80;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Byte monitor: check each accepted byte against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_ch.ready <= 1'b0;
		end else begin
			if (body_ch.valid && body_ch.ready) begin
				if (body_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected body byte %h last %b", $realtime,
							body_ch.byte_out, body_ch.last_byte);
				end else begin
					if (body_ch.byte_out !== body_due[0].value
							|| body_ch.last_byte !== body_due[0].last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: byte %0d expected %h last %b, got %h last %b",
								$realtime, bytes_checked, body_due[0].value, body_due[0].last,
								body_ch.byte_out, body_ch.last_byte);
					end
					void'(body_due.pop_front());
					bytes_checked++;
				end
			end
			body_ch.ready <= (hold_left == 0) && !(take_gaps && $urandom_range(0, 99) < 19);
		end
	end

	// Stimulus and end of run
	initial begin
		wait (arst_n === 1'b1);
		@(negedge clk);

		// directed: VLQ length boundaries, every kind, wrap, end of track
		queue_event(mtes_pkg::KIND_NOTE_ON, 32'd0, 4'd0, 7'd0, 7'd0);
		queue_event(mtes_pkg::KIND_NOTE_ON, track_tick + 32'd127, 4'd15, 7'd127, 7'd127);
		queue_event(mtes_pkg::KIND_NOTE_OFF, track_tick + 32'd128, 4'd5, 7'd60, 7'd100);
		queue_event(mtes_pkg::KIND_PEDAL, track_tick + 32'd16383, 4'd10, 7'd99, 7'd127);
		queue_event(mtes_pkg::KIND_PEDAL, track_tick + 32'd16384, 4'd3, 7'd127, 7'd0);
		queue_event(mtes_pkg::KIND_NOTE_ON, track_tick + 32'h1F_FFFF, 4'd7, 7'd42, 7'd64);
		queue_event(mtes_pkg::KIND_NOTE_OFF, track_tick + 32'h20_0000, 4'd8, 7'd1, 7'd127);
		queue_event(mtes_pkg::KIND_NOTE_ON, track_tick + 32'h0FFF_FFFF, 4'd12, 7'd85, 7'd1);
		queue_event(mtes_pkg::KIND_NOTE_OFF, track_tick + 32'h1000_0000, 4'd1, 7'd126,
			7'd55);
		queue_event(mtes_pkg::KIND_NOTE_ON, 32'hFFFF_FFFF, 4'd15, 7'd127, 7'd127);
		// time going backwards wraps to a one byte delta
		queue_event(mtes_pkg::KIND_NOTE_ON, 32'd5, 4'd2, 7'd33, 7'd90);
		// end of track ignores its fields and restarts the time base
		queue_event(mtes_pkg::KIND_END, 32'hDEAD_BEEF, 4'd9, 7'd77, 7'd33);
		queue_event(mtes_pkg::KIND_NOTE_ON, 32'hFFFF_FFFF, 4'd4, 7'd20, 7'd21);
		queue_event(mtes_pkg::KIND_END, 32'hFFFF_FFFF, 4'd15, 7'd127, 7'd127);
		queue_event(mtes_pkg::KIND_END, 32'd0, 4'd0, 7'd0, 7'd0);
		queue_event(mtes_pkg::KIND_PEDAL, 32'd0, 4'd6, 7'd0, 7'd64);
		queue_event(mtes_pkg::KIND_NOTE_OFF, 32'd0, 4'd15, 7'd127, 7'd127);
		queue_event(mtes_pkg::KIND_END, 32'h8000_0000, 4'd3, 7'd64, 7'd64);
		drain();

		// random with gaps on both sides
		queue_random(50);
		drain();

		// random at full rate on both sides
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		queue_random(28);
		drain();

		// long output stall while events keep coming
		hold_requests++;
		queue_random(14);
		drain();

		repeat (20) @(posedge clk);
		$display("tb_top: %0d events (%0d end of track), %0d body bytes checked, %0d errors",
			events_in, ends_in, bytes_checked, errors);
		$display("tb_top: deltas of 1 to 5 bytes, wraps, gapped and full-rate traffic, a stall");
		if (errors == 0 && body_due.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
